[hw/rtl/tsg_pkg.sv]
// ----------------------------------------------------------------------------
// tsg_pkg: shared types and constants for the tilt/shake gesture detector
// Request and result structs, register indexes, gesture codes, reset values.
// ----------------------------------------------------------------------------
package tsg_pkg;

  typedef struct packed {
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
    logic signed [15:0] raw_z;
    logic [31:0]        now_ms;
  } tsg_in_t;

  typedef struct packed {
    logic [2:0]         gesture;
    logic signed [15:0] corr_x;
    logic signed [15:0] corr_y;
    logic signed [15:0] corr_z;
  } tsg_out_t;

  // per-detector control: evaluate this request, tilt condition, timestamp
  typedef struct packed {
    logic        en;
    logic        tilted;
    logic [31:0] now_ms;
  } tsg_det_req_t;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] REG_OFFSET_X       = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_OFFSET_Y       = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_OFFSET_Z       = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_FORWARD_LIMIT  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_BACKWARD_LIMIT = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_SIDE_LIMIT     = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_SHAKE_JUMP     = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_HOLD_MS        = 3'd7;

  localparam logic [2:0] GEST_NONE     = 3'd0;
  localparam logic [2:0] GEST_FORWARD  = 3'd1;
  localparam logic [2:0] GEST_BACKWARD = 3'd2;
  localparam logic [2:0] GEST_LEFT     = 3'd3;
  localparam logic [2:0] GEST_RIGHT    = 3'd4;
  localparam logic [2:0] GEST_SHAKE    = 3'd5;

  localparam logic signed [15:0] RST_FORWARD_LIMIT  = -16'sd10000;
  localparam logic signed [15:0] RST_BACKWARD_LIMIT = 16'sd14000;
  localparam logic [14:0]        RST_SIDE_LIMIT     = 15'd10000;
  localparam logic [15:0]        RST_SHAKE_JUMP     = 16'd8000;
  localparam logic [15:0]        RST_HOLD_MS        = 16'd1000;

  localparam logic [31:0] SIDE_HOLD_MS    = 32'd500;
  localparam logic [2:0]  SHAKE_RUN_LIMIT = 3'd3;

endpackage

[hw/rtl/tilt_shake_gesture_detector.sv]
// ----------------------------------------------------------------------------
// tilt_shake_gesture_detector: accelerometer tilt and shake gesture detector
// Offset correction, prioritised hold/tilt/shake detectors, one result/sample.
// ----------------------------------------------------------------------------
// Each accepted request (raw x/y/z plus millisecond timestamp) produces
// exactly one result: the offset-corrected sample (wrapped to 16 bits) and a
// gesture code. A request is captured in an input register; the correction
// and all five detectors then run as one short combinational pass into the
// result register, so throughput is one request per cycle while the sink
// does not stall, and out_valid rises when the request moves from the input
// register into the result register. Detectors are evaluated in priority
// order forward hold, backward hold, left, right, shake; only those up to
// and including the first to fire update their state. Registers are written
// through the cfg port (always ready) and should only be changed while no
// request is in flight.
// ----------------------------------------------------------------------------
module tilt_shake_gesture_detector (
  input  logic                              clk,
  input  logic                              rst_n,
  // request channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  tsg_pkg::tsg_in_t                  in_data,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output tsg_pkg::tsg_out_t                 out_data,
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tsg_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [15:0]                       cfg_data
);

  // configuration registers
  logic signed [15:0] offset_x_r, offset_y_r, offset_z_r;
  logic signed [15:0] forward_limit_r, backward_limit_r;
  logic [14:0]        side_limit_r;
  logic [15:0]        shake_jump_r, hold_ms_r;

  // pipeline registers
  logic              in_valid_r;
  tsg_pkg::tsg_in_t  in_data_r;
  logic              out_valid_r;
  tsg_pkg::tsg_out_t out_data_r, out_data_nxt;

  logic adv;           // request moves from input register to result register

  // correction and tilt conditions
  logic signed [15:0] corr_x, corr_y, corr_z;
  logic signed [16:0] corr_y_ext, side_ext;
  logic fwd_tilt, bwd_tilt, y_above, y_below;

  tsg_pkg::tsg_det_req_t fwd_req, bwd_req, left_req, right_req;
  logic fwd_fire, bwd_fire, left_fire, right_fire, shake_fire;
  logic shake_en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_x_r       <= '0;
      offset_y_r       <= '0;
      offset_z_r       <= '0;
      forward_limit_r  <= tsg_pkg::RST_FORWARD_LIMIT;
      backward_limit_r <= tsg_pkg::RST_BACKWARD_LIMIT;
      side_limit_r     <= tsg_pkg::RST_SIDE_LIMIT;
      shake_jump_r     <= tsg_pkg::RST_SHAKE_JUMP;
      hold_ms_r        <= tsg_pkg::RST_HOLD_MS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tsg_pkg::REG_OFFSET_X:       offset_x_r       <= cfg_data;
        tsg_pkg::REG_OFFSET_Y:       offset_y_r       <= cfg_data;
        tsg_pkg::REG_OFFSET_Z:       offset_z_r       <= cfg_data;
        tsg_pkg::REG_FORWARD_LIMIT:  forward_limit_r  <= cfg_data;
        tsg_pkg::REG_BACKWARD_LIMIT: backward_limit_r <= cfg_data;
        tsg_pkg::REG_SIDE_LIMIT:     side_limit_r     <= cfg_data[14:0];
        tsg_pkg::REG_SHAKE_JUMP:     shake_jump_r     <= cfg_data;
        tsg_pkg::REG_HOLD_MS:        hold_ms_r        <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake: input register refills whenever its request moves on, so the
  // input side only stalls while a result waits and the sink stalls.
  assign adv      = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && out_valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data_r <= in_data;
    end
  end

  // offset correction, wrapping
  assign corr_x = in_data_r.raw_x - offset_x_r;
  assign corr_y = in_data_r.raw_y - offset_y_r;
  assign corr_z = in_data_r.raw_z - offset_z_r;

  assign fwd_tilt   = corr_x < forward_limit_r;
  assign bwd_tilt   = corr_x > backward_limit_r;
  // 17-bit compare so that -side_limit is exact
  assign corr_y_ext = {corr_y[15], corr_y};
  assign side_ext   = $signed({2'b00, side_limit_r});
  assign y_above    = corr_y_ext > side_ext;
  assign y_below    = corr_y_ext < -side_ext;

  // priority chain: a detector only steps if none before it fired
  assign fwd_req   = '{en: adv, tilted: fwd_tilt, now_ms: in_data_r.now_ms};
  assign bwd_req   = '{en: adv && !fwd_fire, tilted: bwd_tilt, now_ms: in_data_r.now_ms};
  assign left_req  = '{en: adv && !fwd_fire && !bwd_fire, tilted: y_above,
                       now_ms: in_data_r.now_ms};
  assign right_req = '{en: adv && !fwd_fire && !bwd_fire && !left_fire,
                       tilted: y_below, now_ms: in_data_r.now_ms};
  assign shake_en  = adv && !fwd_fire && !bwd_fire && !left_fire && !right_fire;

  tsg_hold u_fwd (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (fwd_req),
    .hold_ms (hold_ms_r),
    .fire    (fwd_fire)
  );

  tsg_hold u_bwd (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (bwd_req),
    .hold_ms (hold_ms_r),
    .fire    (bwd_fire)
  );

  tsg_side u_left (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (left_req),
    .fire  (left_fire)
  );

  tsg_side u_right (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (right_req),
    .fire  (right_fire)
  );

  tsg_shake u_shake (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (shake_en),
    .corr       ({corr_z, corr_y, corr_x}),
    .shake_jump (shake_jump_r),
    .fire       (shake_fire)
  );

  always_comb begin
    out_data_nxt.corr_x = corr_x;
    out_data_nxt.corr_y = corr_y;
    out_data_nxt.corr_z = corr_z;
    if (fwd_fire) begin
      out_data_nxt.gesture = tsg_pkg::GEST_FORWARD;
    end else if (bwd_fire) begin
      out_data_nxt.gesture = tsg_pkg::GEST_BACKWARD;
    end else if (left_fire) begin
      out_data_nxt.gesture = tsg_pkg::GEST_LEFT;
    end else if (right_fire) begin
      out_data_nxt.gesture = tsg_pkg::GEST_RIGHT;
    end else if (shake_fire) begin
      out_data_nxt.gesture = tsg_pkg::GEST_SHAKE;
    end else begin
      out_data_nxt.gesture = tsg_pkg::GEST_NONE;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[hw/rtl/tsg_hold.sv]
// ----------------------------------------------------------------------------
// tsg_hold: forward/backward hold detector
// Fires once per tilt episode after the tilt has lasted hold_ms.
// ----------------------------------------------------------------------------
module tsg_hold (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tsg_pkg::tsg_det_req_t req,
  input  logic [15:0]          hold_ms,
  output logic                 fire
);

  logic        running_r, running_nxt;
  logic        fired_r, fired_nxt;
  logic [31:0] start_r, start_nxt;
  logic [31:0] elapsed;

  assign elapsed = req.now_ms - start_r;   // wraps mod 2^32
  assign fire    = req.tilted && running_r && !fired_r && (elapsed >= {16'd0, hold_ms});

  always_comb begin
    running_nxt = running_r;
    fired_nxt   = fired_r;
    start_nxt   = start_r;
    if (!req.tilted) begin
      running_nxt = 1'b0;
      fired_nxt   = 1'b0;
    end else if (!running_r) begin
      running_nxt = 1'b1;
      fired_nxt   = 1'b0;
      start_nxt   = req.now_ms;
    end else if (fire) begin
      fired_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      fired_r   <= 1'b0;
    end else if (req.en) begin
      running_r <= running_nxt;
      fired_r   <= fired_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.en) begin
      start_r <= start_nxt;
    end
  end

endmodule

[hw/rtl/tsg_side.sv]
// ----------------------------------------------------------------------------
// tsg_side: left/right tilt detector
// Fires after a fixed side hold time, then restarts the timer.
// ----------------------------------------------------------------------------
module tsg_side (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tsg_pkg::tsg_det_req_t req,
  output logic                 fire
);

  logic        running_r, running_nxt;
  logic [31:0] start_r, start_nxt;
  logic [31:0] elapsed;

  assign elapsed = req.now_ms - start_r;
  assign fire    = req.tilted && running_r && (elapsed >= tsg_pkg::SIDE_HOLD_MS);

  always_comb begin
    running_nxt = running_r;
    start_nxt   = start_r;
    if (!req.tilted) begin
      running_nxt = 1'b0;
    end else if (!running_r) begin
      running_nxt = 1'b1;
      start_nxt   = req.now_ms;
    end else if (fire) begin
      running_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
    end else if (req.en) begin
      running_r <= running_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.en) begin
      start_r <= start_nxt;
    end
  end

endmodule

[hw/rtl/tsg_shake.sv]
// ----------------------------------------------------------------------------
// tsg_shake: shake detector
// Counts consecutive samples with a large per-axis jump; fires past the limit.
// ----------------------------------------------------------------------------
module tsg_shake (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [2:0][15:0] corr,
  input  logic [15:0]      shake_jump,
  output logic             fire
);

  logic [2:0][15:0] prev_r;
  logic [2:0]       run_r, run_nxt;
  logic [2:0]       run_inc;
  logic [2:0]       axis_big;
  logic             big;

  // full-magnitude jump per axis, 17-bit difference, no 16-bit wrap
  always_comb begin
    logic signed [16:0] diff;
    logic        [16:0] mag;
    for (int i = 0; i < 3; i++) begin
      diff = $signed({corr[i][15], corr[i]}) - $signed({prev_r[i][15], prev_r[i]});
      mag  = diff[16] ? 17'(-diff) : 17'(diff);
      axis_big[i] = (mag[15:0] > shake_jump);
    end
  end

  assign big     = |axis_big;
  assign run_inc = run_r + 3'd1;
  assign fire    = big && (run_inc > tsg_pkg::SHAKE_RUN_LIMIT);

  always_comb begin
    if (!big || fire) begin
      run_nxt = 3'd0;
    end else begin
      run_nxt = run_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 3'd0;
      prev_r <= '0;
    end else if (en) begin
      run_r  <= run_nxt;
      prev_r <= corr;
    end
  end

endmodule

[hw/rtl/tsg_checker.sv]
// ----------------------------------------------------------------------------
// tsg_checker: port-level checks for the gesture detector
// Bound to the top level; watches the request, result and reset behaviour.
// ----------------------------------------------------------------------------
module tsg_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input tsg_pkg::tsg_out_t out_data
);

  // no result straight after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // only codes none..shake ever appear
  a_gesture_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.gesture <= tsg_pkg::GEST_SHAKE))
    else $error("gesture code out of range");

  // input side only back-pressures when a result is waiting on a stalled sink
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output back-pressure");

  // a stalled result is held
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result dropped or changed");

endmodule

bind tilt_shake_gesture_detector tsg_checker u_tsg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

[bench/tb_tilt_shake_gesture_detector.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tilt_shake_gesture_detector: self-checking bench for the gesture detector
// Drives accelerometer requests through several register settings and idling
// patterns, predicts every result in-bench and checks each one field by field.
// ----------------------------------------------------------------------------
module tb_tilt_shake_gesture_detector;

  import tsg_pkg::*;

  localparam int NUM_REGS        = 1 << CfgIdxW;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 205;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int DRAIN_CYCLES    = 6;   // out_valid rises once a request reaches the result register
  localparam int MAX_PRINTED     = 50;

  // hold and side timer slots
  localparam int HOLD_FWD   = 0;
  localparam int HOLD_BWD   = 1;
  localparam int SIDE_LEFT  = 0;
  localparam int SIDE_RIGHT = 1;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  tsg_in_t              in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  tsg_out_t             out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CfgIdxW-1:0]   cfg_index = '0;
  logic [15:0]          cfg_data  = '0;

  tilt_shake_gesture_detector u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Bench-side copy of the registers and detector state
  // --------------------------------------------------------------------------
  logic signed [15:0] off_x   = '0;
  logic signed [15:0] off_y   = '0;
  logic signed [15:0] off_z   = '0;
  logic signed [15:0] fwd_lim = RST_FORWARD_LIMIT;
  logic signed [15:0] bwd_lim = RST_BACKWARD_LIMIT;
  logic [14:0]        side_lim = RST_SIDE_LIMIT;
  logic [15:0]        jump_thr = RST_SHAKE_JUMP;
  logic [15:0]        hold_lim = RST_HOLD_MS;

  logic [31:0]        hold_t0   [2] = '{32'd0, 32'd0};
  logic               hold_on   [2] = '{1'b0, 1'b0};
  logic               hold_done [2] = '{1'b0, 1'b0};
  logic [31:0]        side_t0   [2] = '{32'd0, 32'd0};
  logic               side_on   [2] = '{1'b0, 1'b0};
  logic signed [15:0] shake_prev [3] = '{16'sd0, 16'sd0, 16'sd0};
  logic [2:0]         shake_len = '0;

  tsg_in_t  sample_q[$];          // requests waiting for the driver
  tsg_out_t pending_gestures[$];  // predicted results, oldest first

  int          src_idle_pct = 0;
  int          snk_stall_pct = 0;
  int          n_queued   = 0;
  int          n_sent     = 0;
  int          n_checked  = 0;
  int          n_errors   = 0;
  int          stuck_cycles = 0;
  int          gest_seen [8] = '{default: 0};
  logic [31:0] clock_ms   = '0;   // timestamp generator for random traffic

  // Forward/backward hold: fires once per tilt episode after hold_lim ms.
  function automatic logic hold_fires(input int d, input logic tilted,
                                      input logic [31:0] t_ms);
    logic [31:0] elapsed;
    if (!tilted) begin
      hold_on[d]   = 1'b0;
      hold_done[d] = 1'b0;
      hold_t0[d]   = '0;
      return 1'b0;
    end
    if (!hold_on[d]) begin
      hold_on[d]   = 1'b1;
      hold_t0[d]   = t_ms;
      hold_done[d] = 1'b0;
      return 1'b0;
    end
    elapsed = t_ms - hold_t0[d];   // modulo 2^32, so wrap is harmless
    if (!hold_done[d] && elapsed >= {16'd0, hold_lim}) begin
      hold_done[d] = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Left/right tilt: fires after 500 ms and then re-arms.
  function automatic logic side_fires(input int d, input logic tilted,
                                      input logic [31:0] t_ms);
    logic [31:0] elapsed;
    if (!tilted) begin
      side_on[d] = 1'b0;
      side_t0[d] = '0;
      return 1'b0;
    end
    if (!side_on[d]) begin
      side_on[d] = 1'b1;
      side_t0[d] = t_ms;
      return 1'b0;
    end
    elapsed = t_ms - side_t0[d];
    if (elapsed >= SIDE_HOLD_MS) begin
      side_on[d] = 1'b0;
      side_t0[d] = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Shake: full-magnitude jumps per axis, no 16-bit wrap on the difference.
  function automatic logic shake_fires(input logic signed [15:0] cx,
                                       input logic signed [15:0] cy,
                                       input logic signed [15:0] cz);
    int   cur [3];
    int   jump;
    logic big;
    cur = '{int'(cx), int'(cy), int'(cz)};
    big = 1'b0;
    for (int i = 0; i < 3; i++) begin
      jump = cur[i] - int'(shake_prev[i]);
      if (jump < 0) jump = -jump;
      if (jump > int'(jump_thr)) big = 1'b1;
      shake_prev[i] = cur[i][15:0];
    end
    if (big) begin
      shake_len = shake_len + 3'd1;
      if (shake_len > SHAKE_RUN_LIMIT) begin
        shake_len = '0;
        return 1'b1;
      end
    end else begin
      shake_len = '0;
    end
    return 1'b0;
  endfunction

  // Priority chain: later detectors keep their state once one has fired.
  function automatic tsg_out_t predict_gesture(input tsg_in_t s);
    tsg_out_t           r;
    logic signed [15:0] cx, cy, cz;
    int                 side;
    cx   = s.raw_x - off_x;
    cy   = s.raw_y - off_y;
    cz   = s.raw_z - off_z;
    side = int'(side_lim);
    r.corr_x  = cx;
    r.corr_y  = cy;
    r.corr_z  = cz;
    r.gesture = GEST_NONE;
    if (hold_fires(HOLD_FWD, cx < fwd_lim, s.now_ms))
      r.gesture = GEST_FORWARD;
    else if (hold_fires(HOLD_BWD, cx > bwd_lim, s.now_ms))
      r.gesture = GEST_BACKWARD;
    else if (side_fires(SIDE_LEFT, int'(cy) > side, s.now_ms))
      r.gesture = GEST_LEFT;
    else if (side_fires(SIDE_RIGHT, int'(cy) < -side, s.now_ms))
      r.gesture = GEST_RIGHT;
    else if (shake_fires(cx, cy, cz))
      r.gesture = GEST_SHAKE;
    return r;
  endfunction

  function automatic void apply_reg(input logic [CfgIdxW-1:0] idx,
                                    input logic [15:0] val);
    case (idx)
      REG_OFFSET_X:       off_x    = val;
      REG_OFFSET_Y:       off_y    = val;
      REG_OFFSET_Z:       off_z    = val;
      REG_FORWARD_LIMIT:  fwd_lim  = val;
      REG_BACKWARD_LIMIT: bwd_lim  = val;
      REG_SIDE_LIMIT:     side_lim = val[14:0];
      REG_SHAKE_JUMP:     jump_thr = val;
      REG_HOLD_MS:        hold_lim = val;
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic int pick(input int lo, input int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic void queue_raw(input logic [15:0] x, input logic [15:0] y,
                                    input logic [15:0] z, input logic [31:0] t_ms);
    tsg_in_t s;
    s.raw_x  = x;
    s.raw_y  = y;
    s.raw_z  = z;
    s.now_ms = t_ms;
    sample_q.push_back(s);
    n_queued++;
  endfunction

  // One short gesture attempt: mostly well-formed tilt holds and shakes, with
  // the odd off-axis sample and some pure noise. Targets are corrected values;
  // the offsets are added back so the block sees the intended tilt.
  function automatic void queue_episode();
    int kind, len, tx, ty, tz, fl, bl, sd;
    fl   = int'(fwd_lim);
    bl   = int'(bwd_lim);
    sd   = int'(side_lim);
    kind = $urandom_range(99);
    len  = (kind >= 70 && kind < 85) ? $urandom_range(9, 4) : $urandom_range(10, 1);
    for (int k = 0; k < len; k++) begin
      tx = (fl <= bl) ? pick(fl, bl) : pick(-32768, 32767);
      ty = pick(-sd, sd);
      tz = pick(-4000, 4000);
      if ($urandom_range(7) != 0) begin
        if (kind < 20) begin
          if (fl > -32768) tx = pick(-32768, fl - 1);
        end else if (kind < 40) begin
          if (bl < 32767) tx = pick(bl + 1, 32767);
        end else if (kind < 55) begin
          if (sd < 32767) ty = pick(sd + 1, 32767);
        end else if (kind < 70) begin
          ty = pick(-32768, -sd - 1);
        end else if (kind < 85) begin
          tz = (k % 2 != 0) ? pick(-32768, -28000) : pick(28000, 32767);
        end else begin
          tx = pick(-32768, 32767);
          ty = pick(-32768, 32767);
          tz = pick(-32768, 32767);
          if ($urandom_range(1) != 0) clock_ms = $urandom;
        end
      end
      if ($urandom_range(7) != 0)
        clock_ms = clock_ms + $urandom_range(int'(hold_lim) / 3 + 260);
      queue_raw(16'(tx + int'(off_x)), 16'(ty + int'(off_y)),
                16'(tz + int'(off_z)), clock_ms);
    end
  endfunction

  task automatic report_mismatch(input string msg);
    n_errors++;
    if (n_errors <= MAX_PRINTED)
      $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  task automatic check_result(input tsg_out_t got);
    tsg_out_t want;
    if (pending_gestures.size() == 0) begin
      report_mismatch($sformatf("result %h arrived with nothing expected", got));
      return;
    end
    want = pending_gestures.pop_front();
    gest_seen[want.gesture]++;
    if (got.gesture !== want.gesture)
      report_mismatch($sformatf("result %0d gesture %0d, expected %0d",
                                n_checked, got.gesture, want.gesture));
    if (got.corr_x !== want.corr_x)
      report_mismatch($sformatf("result %0d corr_x %0d, expected %0d",
                                n_checked, got.corr_x, want.corr_x));
    if (got.corr_y !== want.corr_y)
      report_mismatch($sformatf("result %0d corr_y %0d, expected %0d",
                                n_checked, got.corr_y, want.corr_y));
    if (got.corr_z !== want.corr_z)
      report_mismatch($sformatf("result %0d corr_z %0d, expected %0d",
                                n_checked, got.corr_z, want.corr_z));
    n_checked++;
  endtask

  // --------------------------------------------------------------------------
  // Request driver: a request once raised holds until accepted; the
  // prediction is made at the edge that accepts it.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_requests
    logic    nxt_valid;
    tsg_in_t nxt_data;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      nxt_valid = in_valid;
      nxt_data  = in_data;
      if (in_valid && !in_stall) begin
        pending_gestures.push_back(predict_gesture(in_data));
        n_sent++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && sample_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        nxt_valid = 1'b1;
        nxt_data  = sample_q.pop_front();
      end
      in_valid <= nxt_valid;
      in_data  <= nxt_data;
    end
  end

  // Result monitor, also owns the receiver stall.
  always @(posedge clk) begin : watch_results
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_result(out_data);
      out_stall <= ($urandom_range(99) < snk_stall_pct);
    end
  end

  // Anything moving on any channel resets the count; a long silence is a hang.
  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no request, result or register write for %0d cycles",
                 stuck_cycles);
        $display("tb_tilt_shake_gesture_detector failed");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequencing
  // --------------------------------------------------------------------------
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_reg(idx, val);
  endtask

  // Wait until every request has gone in and every result has come out.
  task automatic drain();
    do @(negedge clk);
    while (sample_q.size() != 0 || in_valid || pending_gestures.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Register set per phase: a mild set, all ones, all zeros, an edge-value set,
  // then random ones. Side limit bit 15 is set at times to check it is dropped.
  task automatic program_regs(input int ph);
    logic [15:0] v [NUM_REGS];
    case (ph)
      0: begin
        v[REG_OFFSET_X]       = 16'd1234;
        v[REG_OFFSET_Y]       = -16'sd2000;
        v[REG_OFFSET_Z]       = 16'd30000;
        v[REG_FORWARD_LIMIT]  = RST_FORWARD_LIMIT;
        v[REG_BACKWARD_LIMIT] = RST_BACKWARD_LIMIT;
        v[REG_SIDE_LIMIT]     = {1'b0, RST_SIDE_LIMIT};
        v[REG_SHAKE_JUMP]     = RST_SHAKE_JUMP;
        v[REG_HOLD_MS]        = RST_HOLD_MS;
      end
      1: v = '{default: 16'hFFFF};
      2: v = '{default: 16'h0000};
      3: begin
        v[REG_OFFSET_X]       = 16'h7FFF;
        v[REG_OFFSET_Y]       = 16'h8000;
        v[REG_OFFSET_Z]       = 16'hFFFF;
        v[REG_FORWARD_LIMIT]  = 16'h7FFF;
        v[REG_BACKWARD_LIMIT] = 16'h8000;
        v[REG_SIDE_LIMIT]     = 16'h0001;
        v[REG_SHAKE_JUMP]     = 16'h0001;
        v[REG_HOLD_MS]        = 16'h0001;
      end
      default: begin
        v[REG_OFFSET_X]       = 16'($urandom);
        v[REG_OFFSET_Y]       = 16'($urandom);
        v[REG_OFFSET_Z]       = 16'($urandom);
        v[REG_FORWARD_LIMIT]  = 16'(-pick(1, 20000));
        v[REG_BACKWARD_LIMIT] = 16'(pick(1000, 25000));
        v[REG_SIDE_LIMIT]     = {1'($urandom_range(1)), 15'($urandom_range(20000))};
        v[REG_SHAKE_JUMP]     = 16'($urandom_range(40000));
        v[REG_HOLD_MS]        = 16'($urandom_range(3000));
      end
    endcase
    for (int i = 0; i < NUM_REGS; i++) write_reg(i[CfgIdxW-1:0], v[i]);
  endtask

  initial begin : run_test
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed requests at reset register values, no idling.
    queue_raw(16'sd0,      16'sd0,      16'sd0,      32'd0);
    // forward hold: start, too early, fires at exactly hold, then once only
    queue_raw(-16'sd32768, 16'sd0,      16'sd0,      32'd100);
    queue_raw(-16'sd20000, 16'sd0,      16'sd0,      32'd600);
    queue_raw(-16'sd10001, 16'sd0,      16'sd0,      32'd1100);
    queue_raw(-16'sd32768, 16'sd0,      16'sd0,      32'd5000);
    // x exactly on the limit is not a tilt
    queue_raw(-16'sd10000, 16'sd0,      16'sd0,      32'd5100);
    // backward hold
    queue_raw(16'sd32767,  16'sd0,      16'sd0,      32'd6000);
    queue_raw(16'sd14001,  16'sd0,      16'sd0,      32'd6999);
    queue_raw(16'sd14001,  16'sd0,      16'sd0,      32'd7000);
    // left tilt, then right tilt straight after
    queue_raw(16'sd14000,  16'sd32767,  16'sd0,      32'd8000);
    queue_raw(16'sd0,      16'sd10001,  16'sd0,      32'd8499);
    queue_raw(16'sd0,      16'sd10001,  16'sd0,      32'd8500);
    queue_raw(16'sd0,     -16'sd32768,  16'sd0,      32'd8600);
    queue_raw(16'sd0,     -16'sd10001,  16'sd0,      32'd9100);
    // shake: z swinging end to end
    for (int k = 0; k < 5; k++)
      queue_raw(16'sd0, 16'sd0, (k % 2 != 0) ? 16'h8000 : 16'h7FFF, 32'd9200 + k);
    // forward hold across the timestamp wrap
    queue_raw(-16'sd32768, 16'sd0,      16'sd0,      32'hFFFF_FE00);
    queue_raw(-16'sd32768, 16'sd0,      16'sd0,      32'h0000_0100);
    queue_raw(-16'sd32768, 16'sd0,      16'sd0,      32'h0000_0200);
    queue_raw(16'sd32767,  16'sd32767,  16'sd32767,  32'hFFFF_FFFF);
    drain();

    // Zero hold time: fires on the second tilted sample, same timestamp.
    write_reg(REG_HOLD_MS, 16'd0);
    @(negedge clk);
    for (int k = 0; k < 3; k++)
      queue_raw(-16'sd32768, 16'sd0, 16'sd0, 32'h8000_0000);
    drain();

    // Random phases, rotating through the idling patterns.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      int first;
      case (ph % 4)
        0:       begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1:       begin src_idle_pct = 85; snk_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  snk_stall_pct = 85; end
        default: begin src_idle_pct = 36; snk_stall_pct = 36; end
      endcase
      program_regs(ph);
      @(negedge clk);
      clock_ms = (ph % 2 != 0) ? 32'hFFFF_0000 + $urandom_range(65535) : $urandom;
      first = n_queued;
      while (n_queued - first < ITEMS_PER_PHASE) queue_episode();
      drain();
    end

    if (pending_gestures.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_gestures.size()));

    $display("Covered %0d requests over %0d register settings and four idling patterns,",
             n_sent, NUM_PHASES + 2);
    $display("%0d results checked: forward %0d backward %0d left %0d right %0d shake %0d",
             n_checked, gest_seen[GEST_FORWARD], gest_seen[GEST_BACKWARD],
             gest_seen[GEST_LEFT], gest_seen[GEST_RIGHT], gest_seen[GEST_SHAKE]);
    if (n_errors == 0) begin
      $display("tb_tilt_shake_gesture_detector passed");
    end else begin
      $display("tb_tilt_shake_gesture_detector failed");
    end
    $finish;
  end

endmodule
